// File: hdl/rma_pkg.sv
package rma_pkg;

   // table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // field widths
   localparam int ADDR_W = 64;
   localparam int REQ_DATA_W = 3 * ADDR_W;
   localparam int RSP_DATA_W = 72;

   // remainder unit: one quotient bit per cycle
   localparam int DIV_STEPS = ADDR_W;
   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_LOST  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PIDX_HOLD = 2'd0,
      PIDX_INC  = 2'd1,
      PIDX_ZERO = 2'd2
   } pidx_op_type;

   typedef enum logic [2:0] {
      WR_NONE     = 3'd0,
      WR_MRG_PREV = 3'd1,
      WR_MRG_BOTH = 3'd2,
      WR_MRG_NEXT = 3'd3,
      WR_INSERT   = 3'd4,
      WR_CARVE    = 3'd5,
      WR_SHIFT    = 3'd6
   } wr_op_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      pidx_op_type pidx_op;
      wr_op_type   wr_op;
      logic        prev_load;
      logic        m_load;
      logic        div_start;
      logic        div_step;
      logic        m_from_div;
      logic        fit_load;
      logic        gap_setup;
      logic        set_lost;
      logic        out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_kind;
      logic req_len_zero;
      logic scan_cont;
      logic merge_prev;
      logic merge_next;
      logic at_last;
      logic cur_empty;
      logic take_fail;
      logic take_skip;
      logic align_nz;
      logic div_done;
      logic fit_ok;
      logic nlen_zero;
      logic gap_nz;
      logic rsp_free;
   } stat_type;

endpackage

// File: hdl/rma_datapath.sv
module rma_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tuser,
   input  logic [rma_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rma_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  rma_pkg::cmd_type                cmd,
   output rma_pkg::stat_type               stat
);

   localparam int AW = rma_pkg::ADDR_W;
   localparam int IW = rma_pkg::IDX_W;

   // range table
   logic [AW-1:0] start_mem [rma_pkg::ENTRIES];
   logic [AW-1:0] len_mem   [rma_pkg::ENTRIES];
   logic [rma_pkg::ENTRIES-1:0] valid_ff, valid_in;

   logic [AW-1:0] rd_s_ff, rd_l_ff;
   logic          rd_vld_ff;
   logic [AW-1:0] cs, cl;

   logic [IW-1:0] p_ff, p_in, pm1;
   logic [AW-1:0] prev_s_ff, prev_s_in, prev_l_ff, prev_l_in;
   logic [AW-1:0] a_ff, a_in, s_ff, s_in;
   logic [AW-1:0] want_ff, want_in, size_ff, size_in, align_ff, align_in;
   logic [AW-1:0] m_ff, m_in, old_ff, old_in, nlen_ff, nlen_in;
   logic [AW-1:0] x_ff, x_in, xs_ff, xs_in;
   logic [AW:0]   r_ff, r_in;
   logic [rma_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic          is_alloc_ff, is_alloc_in;
   logic          lost_ff, lost_in, chg_ff, chg_in, carved_ff, carved_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_g_ff, rsp_g_in;
   rma_pkg::status_type rsp_st_ff, rsp_st_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [AW-1:0] wr_s, wr_l;

   logic [AW-1:0] req_base, req_len, req_align;
   logic [AW-1:0] diff, m_scan, e_fit, carve_start;
   logic [AW:0]   r_shift, r_sub;
   logic          want_nz, above, t_end;

   assign req_base  = req_tdata[AW-1:0];
   assign req_len   = req_tdata[2*AW-1:AW];
   assign req_align = req_tdata[3*AW-1:2*AW];

   // entries never written read as empty
   assign cs  = rd_vld_ff ? rd_s_ff : '0;
   assign cl  = rd_vld_ff ? rd_l_ff : '0;
   assign pm1 = p_ff - IW'(1);

   // walk index
   always_comb begin
      case (cmd.pidx_op)
         rma_pkg::PIDX_INC:  p_in = p_ff + IW'(1);
         rma_pkg::PIDX_ZERO: p_in = '0;
         default:            p_in = p_ff;
      endcase
   end

   // table write port
   assign carve_start = m_ff + size_ff;
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = p_ff;
      wr_s    = cs;
      wr_l    = cl;
      unique case (cmd.wr_op)
         rma_pkg::WR_MRG_PREV: begin
            wr_addr = pm1;
            wr_s    = prev_s_ff;
            wr_l    = prev_l_ff + s_ff;
         end
         rma_pkg::WR_MRG_BOTH: begin
            wr_addr = pm1;
            wr_s    = prev_s_ff;
            wr_l    = prev_l_ff + cl;
         end
         rma_pkg::WR_MRG_NEXT: begin
            wr_s = cs - s_ff;
            wr_l = cl + s_ff;
         end
         rma_pkg::WR_INSERT: begin
            wr_s = a_ff;
            wr_l = s_ff;
         end
         rma_pkg::WR_CARVE: begin
            wr_s = carve_start;
            wr_l = nlen_ff;
         end
         rma_pkg::WR_SHIFT: begin
            wr_addr = pm1;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_s;
         len_mem[wr_addr]   <= wr_l;
      end
      rd_s_ff <= start_mem[p_in];
      rd_l_ff <= len_mem[p_in];
   end

   // first-fit candidate for the current entry
   assign want_nz = want_ff != '0;
   assign diff    = want_ff - cs;
   assign above   = cs > want_ff;
   assign t_end   = (p_ff == rma_pkg::LAST_IDX) || (cl == '0);
   assign m_scan  = want_nz ? want_ff : cs;
   assign e_fit   = cs + cl - m_ff;

   // remainder step for alignment round-up
   assign r_shift = {r_ff[AW-1:0], x_ff[AW-1]};
   assign r_sub   = r_shift - {1'b0, align_ff};

   always_comb begin
      prev_s_in   = cmd.prev_load ? cs : prev_s_ff;
      prev_l_in   = prev_l_ff;
      if (cmd.prev_load) begin
         prev_l_in = cl;
      end else if (cmd.wr_op == rma_pkg::WR_MRG_PREV) begin
         prev_l_in = prev_l_ff + s_ff;
      end

      a_in = a_ff;
      s_in = s_ff;
      if (cmd.load) begin
         a_in = req_base;
         s_in = req_len;
      end else if (cmd.wr_op == rma_pkg::WR_INSERT) begin
         a_in = cs;
         s_in = cl;
      end else if (cmd.gap_setup) begin
         a_in = old_ff;
         s_in = m_ff - old_ff;
      end

      want_in     = cmd.load ? req_base : want_ff;
      size_in     = cmd.load ? req_len : size_ff;
      align_in    = cmd.load ? req_align : align_ff;
      is_alloc_in = cmd.load ? req_tuser : is_alloc_ff;

      m_in = m_ff;
      if (cmd.m_load) begin
         m_in = m_scan;
      end else if (cmd.m_from_div) begin
         m_in = xs_ff - r_ff[AW-1:0];
      end

      x_in   = x_ff;
      xs_in  = xs_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         x_in   = m_scan + align_ff - AW'(1);
         xs_in  = m_scan + align_ff - AW'(1);
         r_in   = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         x_in   = {x_ff[AW-2:0], 1'b0};
         r_in   = (r_shift >= {1'b0, align_ff}) ? r_sub : r_shift;
         cnt_in = cnt_ff + rma_pkg::CNT_W'(1);
      end

      nlen_in = cmd.fit_load ? e_fit - size_ff : nlen_ff;
      old_in  = (cmd.wr_op == rma_pkg::WR_CARVE) ? cs : old_ff;

      chg_in    = chg_ff;
      carved_in = carved_ff;
      lost_in   = lost_ff;
      if (cmd.load) begin
         chg_in    = 1'b0;
         carved_in = 1'b0;
         lost_in   = 1'b0;
      end else begin
         case (cmd.wr_op)
            rma_pkg::WR_CARVE: begin
               carved_in = 1'b1;
               chg_in    = chg_ff | (carve_start != cs);
            end
            rma_pkg::WR_MRG_PREV, rma_pkg::WR_MRG_BOTH,
            rma_pkg::WR_MRG_NEXT, rma_pkg::WR_INSERT: chg_in = 1'b1;
            default: chg_in = chg_ff;
         endcase
         if (cmd.set_lost) begin
            lost_in = 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);
      rsp_g_in     = rsp_g_ff;
      rsp_st_in    = rsp_st_ff;
      if (cmd.out_load) begin
         if (!is_alloc_ff) begin
            rsp_g_in  = '0;
            rsp_st_in = lost_ff ? rma_pkg::ST_LOST : rma_pkg::ST_OK;
         end else if (!carved_ff) begin
            rsp_g_in  = '1;
            rsp_st_in = rma_pkg::ST_NOFIT;
         end else begin
            rsp_g_in = m_ff;
            // an all-ones grant that left the table untouched reads as failure
            if (!chg_ff && m_ff == '1) begin
               rsp_st_in = rma_pkg::ST_NOFIT;
            end else begin
               rsp_st_in = lost_ff ? rma_pkg::ST_LOST : rma_pkg::ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         is_alloc_ff  <= 1'b0;
         lost_ff      <= 1'b0;
         chg_ff       <= 1'b0;
         carved_ff    <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rd_vld_ff    <= valid_ff[p_in];
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         is_alloc_ff  <= is_alloc_in;
         lost_ff      <= lost_in;
         chg_ff       <= chg_in;
         carved_ff    <= carved_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_s_ff <= prev_s_in;
      prev_l_ff <= prev_l_in;
      a_ff      <= a_in;
      s_ff      <= s_in;
      want_ff   <= want_in;
      size_ff   <= size_in;
      align_ff  <= align_in;
      m_ff      <= m_in;
      old_ff    <= old_in;
      nlen_ff   <= nlen_in;
      x_ff      <= x_in;
      xs_ff     <= xs_in;
      r_ff      <= r_in;
      rsp_g_ff  <= rsp_g_in;
      rsp_st_ff <= rsp_st_in;
   end

   // status to the controller
   always_comb begin
      stat.req_kind     = req_tuser;
      stat.req_len_zero = req_len == '0;
      stat.scan_cont    = (p_ff != rma_pkg::LAST_IDX) && (cl != '0) && (cs <= a_ff);
      stat.merge_prev   = (p_ff != '0) && (prev_s_ff + prev_l_ff == a_ff);
      stat.merge_next   = (cl != '0) && (a_ff + s_ff == cs);
      stat.at_last      = p_ff == rma_pkg::LAST_IDX;
      stat.cur_empty    = cl == '0;
      stat.take_fail    = t_end || (want_nz && (above ||
                          (!(cl < diff) && (diff > cl - size_ff))));
      stat.take_skip    = !t_end && want_nz && !above && (cl < diff);
      stat.align_nz     = align_ff != '0;
      stat.div_done     = cnt_ff == rma_pkg::CNT_W'(rma_pkg::DIV_STEPS);
      stat.fit_ok       = !(e_fit < size_ff);
      stat.nlen_zero    = nlen_ff == '0;
      stat.gap_nz       = old_ff != m_ff;
      stat.rsp_free     = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rma_pkg::RSP_DATA_W - AW - 2){1'b0}}, rsp_st_ff, rsp_g_ff};

`ifndef NO_ASSERTIONS
   // the closing slot of the table is never filled
   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr != rma_pkg::LAST_IDX)
      else $error("write to last table slot");

   // a failed allocation always grants all ones
   a_nofit_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff == rma_pkg::ST_NOFIT |-> rsp_g_ff == '1)
      else $error("no-fit result without all-ones address");

   // partial remainder stays below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> r_ff < {1'b0, align_ff})
      else $error("remainder out of range");
`endif

endmodule

// File: hdl/rma_control.sv
module rma_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rma_pkg::stat_type  stat,
   output rma_pkg::cmd_type   cmd
);

   typedef enum logic [15:0] {
      S_IDLE    = 16'b0000_0000_0000_0001,
      S_T_START = 16'b0000_0000_0000_0010,
      S_T_SCAN  = 16'b0000_0000_0000_0100,
      S_T_DIV   = 16'b0000_0000_0000_1000,
      S_T_FIT   = 16'b0000_0000_0001_0000,
      S_T_CARVE = 16'b0000_0000_0010_0000,
      S_T_DEL   = 16'b0000_0000_0100_0000,
      S_T_GAP   = 16'b0000_0000_1000_0000,
      S_P_START = 16'b0000_0001_0000_0000,
      S_P_SCAN  = 16'b0000_0010_0000_0000,
      S_P_DEC   = 16'b0000_0100_0000_0000,
      S_P_MRG2  = 16'b0000_1000_0000_0000,
      S_P_DEL1  = 16'b0001_0000_0000_0000,
      S_P_DEL2  = 16'b0010_0000_0000_0000,
      S_P_INS   = 16'b0100_0000_0000_0000,
      S_DONE    = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = state_ff == S_IDLE;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.pidx_op = rma_pkg::PIDX_HOLD;
      cmd.wr_op   = rma_pkg::WR_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load    = 1'b1;
               cmd.pidx_op = rma_pkg::PIDX_ZERO;
               if (stat.req_kind) begin
                  state_in = S_T_START;
               end else if (stat.req_len_zero) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_P_START;
               end
            end
         end
         S_T_START: state_in = S_T_SCAN;
         S_T_SCAN: begin
            if (stat.take_fail) begin
               state_in = S_DONE;
            end else if (stat.take_skip) begin
               cmd.pidx_op = rma_pkg::PIDX_INC;
            end else begin
               cmd.m_load = 1'b1;
               if (stat.align_nz) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_T_DIV;
               end else begin
                  state_in = S_T_FIT;
               end
            end
         end
         S_T_DIV: begin
            if (stat.div_done) begin
               cmd.m_from_div = 1'b1;
               state_in       = S_T_FIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_T_FIT: begin
            if (stat.fit_ok) begin
               cmd.fit_load = 1'b1;
               state_in     = S_T_CARVE;
            end else begin
               cmd.pidx_op = rma_pkg::PIDX_INC;
               state_in    = S_T_SCAN;
            end
         end
         S_T_CARVE: begin
            cmd.wr_op = rma_pkg::WR_CARVE;
            if (stat.nlen_zero) begin
               cmd.pidx_op = rma_pkg::PIDX_INC;
               state_in    = S_T_DEL;
            end else begin
               state_in = S_T_GAP;
            end
         end
         S_T_DEL: begin
            cmd.wr_op = rma_pkg::WR_SHIFT;
            if (stat.cur_empty || stat.at_last) begin
               state_in = S_T_GAP;
            end else begin
               cmd.pidx_op = rma_pkg::PIDX_INC;
            end
         end
         S_T_GAP: begin
            // alignment gap goes back through the free path
            if (stat.gap_nz) begin
               cmd.gap_setup = 1'b1;
               cmd.pidx_op   = rma_pkg::PIDX_ZERO;
               state_in      = S_P_START;
            end else begin
               state_in = S_DONE;
            end
         end
         S_P_START: state_in = S_P_SCAN;
         S_P_SCAN: begin
            if (stat.scan_cont) begin
               cmd.prev_load = 1'b1;
               cmd.pidx_op   = rma_pkg::PIDX_INC;
            end else begin
               state_in = S_P_DEC;
            end
         end
         S_P_DEC: begin
            if (stat.merge_prev) begin
               cmd.wr_op = rma_pkg::WR_MRG_PREV;
               state_in  = stat.merge_next ? S_P_MRG2 : S_DONE;
            end else if (stat.merge_next) begin
               cmd.wr_op = rma_pkg::WR_MRG_NEXT;
               state_in  = S_DONE;
            end else begin
               state_in = S_P_INS;
            end
         end
         S_P_MRG2: begin
            cmd.wr_op = rma_pkg::WR_MRG_BOTH;
            state_in  = S_P_DEL1;
         end
         S_P_DEL1: begin
            if (!stat.at_last && !stat.cur_empty) begin
               cmd.pidx_op = rma_pkg::PIDX_INC;
               state_in    = S_P_DEL2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_P_DEL2: begin
            cmd.wr_op = rma_pkg::WR_SHIFT;
            if (!stat.at_last && !stat.cur_empty) begin
               cmd.pidx_op = rma_pkg::PIDX_INC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_P_INS: begin
            if (stat.at_last) begin
               cmd.set_lost = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.wr_op = rma_pkg::WR_INSERT;
               if (stat.cur_empty) begin
                  state_in = S_DONE;
               end else begin
                  cmd.pidx_op = rma_pkg::PIDX_INC;
               end
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/range_map_allocator.sv
// Free-range map with first-fit allocation.
// Input channel req_*: one item per request. req_tuser is the kind
// (0 = free a range, 1 = allocate); req_tdata carries base address,
// length and alignment. Result channel rsp_*: exactly one item per
// request, with granted address and status (ok, no fit, range lost).
// One request is handled at a time; req_tready is high only while the
// sequencer is idle, and a finished result waits in the output register.
// Each request walks the 16-entry table:
//   free:  a scan over the entries, then a merge, insert or shift of entries.
//   alloc: a scan over the candidates, through the bit-serial remainder unit
//          for each candidate when alignment is non-zero, plus entry deletion
//          and, for an alignment gap, a following free walk.
// Reset empties the table at once (per-entry valid bits) and drops any
// pending result. If the receiver stalls, the result holds and the next
// request is accepted only after the current result has been loaded.
module range_map_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,  // kind
   // base_address, length, alignment
   input  logic [rma_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // granted_address, status, zero fill
   output logic [rma_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   rma_pkg::cmd_type  cmd;
   rma_pkg::stat_type stat;

   rma_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rma_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
